[rtl/sos_pkg.sv]
// sos_pkg: widths, micro-op and branch codes, and the control store of the
// sum of squares decomposer. No dependencies.
package sos_pkg;

  localparam int NUM_WIDTH  = 16;                      // datapath width of a number
  localparam int FIELD_W    = 16;                      // width of the item fields
  localparam int WIDE_W     = (NUM_WIDTH > FIELD_W) ? NUM_WIDTH : FIELD_W;
  localparam int SQ_BITS    = (NUM_WIDTH + 1) / 2;     // width of a square root
  localparam int SQ_VW      = 2 * SQ_BITS;             // isqrt working width
  localparam int TERM_SLOTS = 4;
  localparam int DEPTH_W    = 2;                       // indexes TERM_SLOTS levels
  localparam int LIMIT_W    = 3;
  localparam int STEP_W     = 5;

  localparam logic [LIMIT_W-1:0] MAX_TERMS_RESET = LIMIT_W'(4);
  localparam logic [LIMIT_W-1:0] MAX_LIMIT       = LIMIT_W'(TERM_SLOTS);

  // micro-ops
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;  // take number and limit, depth 0
  localparam logic [3:0] OP_ISQ_START = 4'd2;  // isqrt of current remainder
  localparam logic [3:0] OP_TAKE_ROOT = 4'd3;  // push largest root, descend
  localparam logic [3:0] OP_TAKE_LAST = 4'd4;  // last level: term = remainder
  localparam logic [3:0] OP_POP       = 4'd5;  // back to the level above
  localparam logic [3:0] OP_NEXT_ROOT = 4'd6;  // root - 1, descend again
  localparam logic [3:0] OP_CLR_TERM  = 4'd7;  // level exhausted
  localparam logic [3:0] OP_DONE_OK   = 4'd8;
  localparam logic [3:0] OP_DONE_FAIL = 4'd9;

  // branch conditions
  localparam logic [3:0] C_NEVER       = 4'd0;
  localparam logic [3:0] C_ALWAYS      = 4'd1;
  localparam logic [3:0] C_NO_ACCEPT   = 4'd2;
  localparam logic [3:0] C_REM_ZERO    = 4'd3;
  localparam logic [3:0] C_DEPTH_GE    = 4'd4;
  localparam logic [3:0] C_ISQ_BUSY    = 4'd5;
  localparam logic [3:0] C_NOT_LAST    = 4'd6;
  localparam logic [3:0] C_NOT_PERFECT = 4'd7;
  localparam logic [3:0] C_DEPTH_ZERO  = 4'd8;
  localparam logic [3:0] C_ROOT_ZERO   = 4'd9;
  localparam logic [3:0] C_OUT_FULL    = 4'd10;

  // control store addresses
  localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
  localparam logic [STEP_W-1:0] S_ENTER     = 5'd1;
  localparam logic [STEP_W-1:0] S_CHK_LIMIT = 5'd2;
  localparam logic [STEP_W-1:0] S_ISQ       = 5'd3;
  localparam logic [STEP_W-1:0] S_ISQ_WAIT  = 5'd4;
  localparam logic [STEP_W-1:0] S_CHK_LAST  = 5'd5;
  localparam logic [STEP_W-1:0] S_CHK_SQ    = 5'd6;
  localparam logic [STEP_W-1:0] S_TAKE_LAST = 5'd7;
  localparam logic [STEP_W-1:0] S_TAKE_ROOT = 5'd8;
  localparam logic [STEP_W-1:0] S_RETURN    = 5'd9;
  localparam logic [STEP_W-1:0] S_POP       = 5'd10;
  localparam logic [STEP_W-1:0] S_CHK_ROOT  = 5'd11;
  localparam logic [STEP_W-1:0] S_NEXT_ROOT = 5'd12;
  localparam logic [STEP_W-1:0] S_CLR_TERM  = 5'd13;
  localparam logic [STEP_W-1:0] S_OK_WAIT   = 5'd14;
  localparam logic [STEP_W-1:0] S_OK        = 5'd15;
  localparam logic [STEP_W-1:0] S_FAIL_WAIT = 5'd16;
  localparam logic [STEP_W-1:0] S_FAIL      = 5'd17;

  typedef struct packed {
    logic [3:0]        op;
    logic [3:0]        cond;    // branch taken when true
    logic [STEP_W-1:0] target;  // else fall through to the next step
  } ucode_t;

  typedef struct packed {
    logic rem_zero;
    logic depth_ge;
    logic isq_busy;
    logic last_level;
    logic perfect;
    logic depth_zero;
    logic root_zero;
  } dp_flags_t;

  typedef struct packed {
    logic [3:0] op;
    logic       idle;
  } seq_ctl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      S_IDLE:      w = '{OP_LOAD,      C_NO_ACCEPT,   S_IDLE};
      S_ENTER:     w = '{OP_NONE,      C_REM_ZERO,    S_OK_WAIT};
      S_CHK_LIMIT: w = '{OP_NONE,      C_DEPTH_GE,    S_RETURN};
      S_ISQ:       w = '{OP_ISQ_START, C_NEVER,       S_IDLE};
      S_ISQ_WAIT:  w = '{OP_NONE,      C_ISQ_BUSY,    S_ISQ_WAIT};
      S_CHK_LAST:  w = '{OP_NONE,      C_NOT_LAST,    S_TAKE_ROOT};
      S_CHK_SQ:    w = '{OP_NONE,      C_NOT_PERFECT, S_RETURN};
      S_TAKE_LAST: w = '{OP_TAKE_LAST, C_ALWAYS,      S_OK_WAIT};
      S_TAKE_ROOT: w = '{OP_TAKE_ROOT, C_ALWAYS,      S_ENTER};
      S_RETURN:    w = '{OP_NONE,      C_DEPTH_ZERO,  S_FAIL_WAIT};
      S_POP:       w = '{OP_POP,       C_NEVER,       S_IDLE};
      S_CHK_ROOT:  w = '{OP_NONE,      C_ROOT_ZERO,   S_CLR_TERM};
      S_NEXT_ROOT: w = '{OP_NEXT_ROOT, C_ALWAYS,      S_ENTER};
      S_CLR_TERM:  w = '{OP_CLR_TERM,  C_ALWAYS,      S_RETURN};
      S_OK_WAIT:   w = '{OP_NONE,      C_OUT_FULL,    S_OK_WAIT};
      S_OK:        w = '{OP_DONE_OK,   C_ALWAYS,      S_IDLE};
      S_FAIL_WAIT: w = '{OP_NONE,      C_OUT_FULL,    S_FAIL_WAIT};
      S_FAIL:      w = '{OP_DONE_FAIL, C_ALWAYS,      S_IDLE};
      default:     w = '{OP_NONE,      C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/sos_ifs.sv]
// sos_in_if / sos_out_if: valid/ready channels of the decomposer.
// Depends on sos_pkg for the field width.
interface sos_in_if;
  logic                        valid;
  logic                        ready;
  logic [sos_pkg::FIELD_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface sos_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [sos_pkg::FIELD_W-1:0] term_0;
  logic [sos_pkg::FIELD_W-1:0] term_1;
  logic [sos_pkg::FIELD_W-1:0] term_2;
  logic [sos_pkg::FIELD_W-1:0] term_3;

  modport source (output valid, output found, output term_0, output term_1,
                  output term_2, output term_3, input ready);
  modport sink   (input valid, input found, input term_0, input term_1,
                  input term_2, input term_3, output ready);
endinterface

[rtl/sum_of_squares_decomposer.sv]
// sum_of_squares_decomposer: top level, config register and result register.
// Depends on sos_pkg, sos_ifs, sos_seq and sos_datapath.
//
// Usage
//   in_if  : valid/ready, one number per item. Taken only while the
//            sequencer sits at its idle step; one number is worked at a time.
//   out_if : valid/ready, one result per number: found plus four square
//            terms, largest chosen first, unused terms zero. A failed search
//            returns found = 0 with all terms zero.
//   cfg_*  : cfg_wr_en writes max_terms (3 bits) from cfg_wr_data; values
//            above four act as four. Write only while the block is idle.
// Search
//   Depth-first search, largest root first, driven by an 18-step micro
//   program. A number that needs more terms than allowed walks the whole
//   tree before it is reported as failed.
// Reset (rst_n low, synchronous): sequencer to idle, output empty,
//   max_terms back to 4.
// Stall: the result register holds one result; a new number may be taken
//   while it waits, and that search stalls at its end until the slot frees.
module sum_of_squares_decomposer (
  input  logic                          clk,
  input  logic                          rst_n,
  sos_in_if.sink                        in_if,
  sos_out_if.source                     out_if,
  input  logic                          cfg_wr_en,
  input  logic [sos_pkg::LIMIT_W-1:0]   cfg_wr_data
);

  logic [sos_pkg::LIMIT_W-1:0] max_terms_r, max_terms_nxt;
  logic [sos_pkg::LIMIT_W-1:0] limit;
  logic                        in_fire;

  sos_pkg::seq_ctl_t           ctl;
  sos_pkg::dp_flags_t          flags;
  logic [sos_pkg::FIELD_W-1:0] terms [sos_pkg::TERM_SLOTS];

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic                        found_r;
  logic [sos_pkg::FIELD_W-1:0] term_r [sos_pkg::TERM_SLOTS];

  assign in_if.ready = ctl.idle;
  assign in_fire     = in_if.valid && ctl.idle;

  // saturate: only four term slots exist
  assign limit = (max_terms_r > sos_pkg::MAX_LIMIT) ? sos_pkg::MAX_LIMIT : max_terms_r;

  sos_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .flags    (flags),
    .in_fire  (in_fire),
    .out_full (out_valid_r),
    .ctl      (ctl)
  );

  sos_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (ctl.op),
    .in_number (in_if.number),
    .limit     (limit),
    .flags     (flags),
    .terms     (terms)
  );

  assign max_terms_nxt = cfg_wr_en ? cfg_wr_data : max_terms_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    // the micro program only reaches a done step with the slot empty
    if (ctl.op == sos_pkg::OP_DONE_OK || ctl.op == sos_pkg::OP_DONE_FAIL) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_terms_r <= sos_pkg::MAX_TERMS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      max_terms_r <= max_terms_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == sos_pkg::OP_DONE_OK) begin
      found_r <= 1'b1;
      for (int i = 0; i < sos_pkg::TERM_SLOTS; i++) begin
        term_r[i] <= terms[i];
      end
    end else if (ctl.op == sos_pkg::OP_DONE_FAIL) begin
      found_r <= 1'b0;
      for (int i = 0; i < sos_pkg::TERM_SLOTS; i++) begin
        term_r[i] <= '0;
      end
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.found  = found_r;
  assign out_if.term_0 = term_r[0];
  assign out_if.term_1 = term_r[1];
  assign out_if.term_2 = term_r[2];
  assign out_if.term_3 = term_r[3];

`ifndef SYNTHESIS
  // a result appears only right after a done step
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      ($past(ctl.op) == sos_pkg::OP_DONE_OK || $past(ctl.op) == sos_pkg::OP_DONE_FAIL))
    else $error("result raised without a done step");

  // a done step never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == sos_pkg::OP_DONE_OK || ctl.op == sos_pkg::OP_DONE_FAIL) |-> !out_valid_r)
    else $error("done step with result slot full");

  // a failed search reports no terms
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |->
      (term_r[0] == '0 && term_r[1] == '0 && term_r[2] == '0 && term_r[3] == '0))
    else $error("failed result carries terms");

  // the isqrt unit is idle whenever a new number may enter
  a_idle_isqrt: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.idle |-> !flags.isq_busy)
    else $error("isqrt busy at idle step");
`endif

endmodule

[rtl/sos_isqrt.sv]
// sos_isqrt: integer square root, one result bit per cycle.
// Depends on sos_pkg for widths.
module sos_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sos_pkg::NUM_WIDTH-1:0] operand,
  output logic                          busy,
  output logic [sos_pkg::SQ_BITS-1:0]   root,
  output logic [sos_pkg::NUM_WIDTH-1:0] rest   // operand - root^2
);

  localparam int VW = sos_pkg::SQ_VW;

  logic [VW-1:0] v_r, v_nxt;
  logic [VW-1:0] res_r, res_nxt;
  logic [VW-1:0] sq_bit_r, sq_bit_nxt;
  logic [VW:0]   trial;

  assign trial = {1'b0, res_r} + {1'b0, sq_bit_r};

  always_comb begin
    v_nxt      = v_r;
    res_nxt    = res_r;
    sq_bit_nxt = sq_bit_r;
    if (start) begin
      v_nxt      = VW'(operand);
      res_nxt    = '0;
      sq_bit_nxt = VW'(1) << (VW - 2);
    end else if (sq_bit_r != '0) begin
      if ({1'b0, v_r} >= trial) begin
        v_nxt   = v_r - trial[VW-1:0];
        res_nxt = (res_r >> 1) + sq_bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      sq_bit_nxt = sq_bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bit_r <= '0;
    end else begin
      sq_bit_r <= sq_bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
  end

  assign busy = (sq_bit_r != '0);
  assign root = res_r[sos_pkg::SQ_BITS-1:0];
  assign rest = v_r[sos_pkg::NUM_WIDTH-1:0];

endmodule

[rtl/sos_seq.sv]
// sos_seq: step counter over the control store, with conditional jumps.
// Depends on sos_pkg for the control store and codes.
module sos_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  sos_pkg::dp_flags_t flags,
  input  logic               in_fire,
  input  logic               out_full,
  output sos_pkg::seq_ctl_t  ctl
);

  logic [sos_pkg::STEP_W-1:0] step_r, step_nxt;
  sos_pkg::ucode_t            cw;
  logic                       take;

  assign cw = sos_pkg::ucode_rom(step_r);

  always_comb begin
    unique case (cw.cond)
      sos_pkg::C_NEVER:       take = 1'b0;
      sos_pkg::C_ALWAYS:      take = 1'b1;
      sos_pkg::C_NO_ACCEPT:   take = !in_fire;
      sos_pkg::C_REM_ZERO:    take = flags.rem_zero;
      sos_pkg::C_DEPTH_GE:    take = flags.depth_ge;
      sos_pkg::C_ISQ_BUSY:    take = flags.isq_busy;
      sos_pkg::C_NOT_LAST:    take = !flags.last_level;
      sos_pkg::C_NOT_PERFECT: take = !flags.perfect;
      sos_pkg::C_DEPTH_ZERO:  take = flags.depth_zero;
      sos_pkg::C_ROOT_ZERO:   take = flags.root_zero;
      sos_pkg::C_OUT_FULL:    take = out_full;
      default:                take = 1'b1;
    endcase
    step_nxt = take ? cw.target : step_r + sos_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sos_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctl.op   = cw.op;
  assign ctl.idle = (step_r == sos_pkg::S_IDLE);

endmodule

[rtl/sos_datapath.sv]
// sos_datapath: search stack (remainder, root, term per level), depth
// pointer and the shared isqrt unit. Depends on sos_pkg and sos_isqrt.
module sos_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [3:0]                    op,
  input  logic [sos_pkg::FIELD_W-1:0]   in_number,
  input  logic [sos_pkg::LIMIT_W-1:0]   limit,
  output sos_pkg::dp_flags_t            flags,
  output logic [sos_pkg::FIELD_W-1:0]   terms [sos_pkg::TERM_SLOTS]
);

  localparam int NW = sos_pkg::NUM_WIDTH;

  logic [sos_pkg::DEPTH_W-1:0] depth_r, depth_nxt, depth_up;
  logic [sos_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic [NW-1:0]               rem_r  [sos_pkg::TERM_SLOTS];
  logic [sos_pkg::SQ_BITS-1:0] root_r [sos_pkg::TERM_SLOTS];
  logic [NW-1:0]               term_r [sos_pkg::TERM_SLOTS];

  logic [NW-1:0]               cur_rem, cur_term, odd, sq_dec;
  logic [sos_pkg::SQ_BITS-1:0] cur_root;
  logic [sos_pkg::WIDE_W-1:0]  num_wide;
  logic                        isq_busy;
  logic [sos_pkg::SQ_BITS-1:0] isq_root;
  logic [NW-1:0]               isq_rest;

  sos_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (op == sos_pkg::OP_ISQ_START),
    .operand (cur_rem),
    .busy    (isq_busy),
    .root    (isq_root),
    .rest    (isq_rest)
  );

  assign depth_up = depth_r + sos_pkg::DEPTH_W'(1);
  assign cur_rem  = rem_r[depth_r];
  assign cur_term = term_r[depth_r];
  assign cur_root = root_r[depth_r];
  assign num_wide = sos_pkg::WIDE_W'(in_number);
  // (r-1)^2 = r^2 - (2r - 1)
  assign odd      = NW'({cur_root, 1'b0}) - NW'(1);
  assign sq_dec   = cur_term - odd;

  always_comb begin
    depth_nxt = depth_r;
    limit_nxt = limit_r;
    unique case (op)
      sos_pkg::OP_LOAD: begin
        depth_nxt = '0;
        limit_nxt = limit;
      end
      sos_pkg::OP_TAKE_ROOT, sos_pkg::OP_NEXT_ROOT: depth_nxt = depth_up;
      sos_pkg::OP_POP:                              depth_nxt = depth_r - sos_pkg::DEPTH_W'(1);
      default:                                      depth_nxt = depth_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      limit_r <= sos_pkg::MAX_TERMS_RESET;
    end else begin
      depth_r <= depth_nxt;
      limit_r <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      sos_pkg::OP_LOAD: begin
        rem_r[0] <= num_wide[NW-1:0];
        for (int i = 0; i < sos_pkg::TERM_SLOTS; i++) begin
          term_r[i] <= '0;
        end
      end
      sos_pkg::OP_TAKE_ROOT: begin
        root_r[depth_r] <= isq_root;
        term_r[depth_r] <= cur_rem - isq_rest;
        rem_r[depth_up] <= isq_rest;
      end
      sos_pkg::OP_TAKE_LAST: term_r[depth_r] <= cur_rem;
      sos_pkg::OP_NEXT_ROOT: begin
        root_r[depth_r] <= cur_root - sos_pkg::SQ_BITS'(1);
        term_r[depth_r] <= sq_dec;
        rem_r[depth_up] <= cur_rem - sq_dec;
      end
      sos_pkg::OP_CLR_TERM:  term_r[depth_r] <= '0;
      default: ;
    endcase
  end

  always_comb begin
    flags.rem_zero   = (cur_rem == '0);
    flags.depth_ge   = (sos_pkg::LIMIT_W'(depth_r) >= limit_r);
    flags.isq_busy   = isq_busy;
    flags.last_level = (sos_pkg::LIMIT_W'(depth_r) + sos_pkg::LIMIT_W'(1) == limit_r);
    flags.perfect    = (isq_rest == '0);
    flags.depth_zero = (depth_r == '0);
    flags.root_zero  = (cur_root == '0);
  end

  for (genvar g = 0; g < sos_pkg::TERM_SLOTS; g++) begin : g_terms
    logic [sos_pkg::WIDE_W-1:0] term_wide;
    assign term_wide = sos_pkg::WIDE_W'(term_r[g]);
    assign terms[g]  = term_wide[sos_pkg::FIELD_W-1:0];
  end

endmodule
